### rtl/idq_pkg.sv
// Package for the id queue: request codes, state machine states and the
// control group that the top level broadcasts to the row of cells.
// Used by idq_cell and id_queue_with_removal; depends on nothing else.
package idq_pkg;

    // Request codes as they arrive on the input channel.
    typedef enum logic [2:0] {
        REQ_ADD        = 3'd0,
        REQ_POLL       = 3'd1,
        REQ_REMOVE     = 3'd2,
        REQ_CONTAINS   = 3'd3,
        REQ_REWIND     = 3'd4,
        REQ_NEXT       = 3'd5,
        REQ_REMOVE_CUR = 3'd6
    } t_req;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_EXEC
    } t_state;

    // Which cells close the gap during a removal.
    typedef enum logic [1:0] {
        KILL_NONE,
        KILL_ALL,
        KILL_HIT,
        KILL_CURSOR
    } t_kill;

    // Control group sent to every cell.
    typedef struct packed {
        logic  cmp;
        logic  load;
        logic  shift;
        t_kill kill;
    } t_cell_ctl;

endpackage

### rtl/idq_cell.sv
// One cell of the id queue row: holds one entry and its match flag.
// Depends on idq_pkg for the control group; instantiated by id_queue_with_removal.
module idq_cell #(
    parameter int IDX     = 0,
    parameter int CNT_W   = 7,
    parameter int ID_BITS = 16
) (
    input  logic                   i_clk,
    input  idq_pkg::t_cell_ctl     i_ctl,
    input  logic [ID_BITS-1:0]     i_value,
    input  logic [CNT_W-1:0]       i_count,
    input  logic [CNT_W-1:0]       i_cursor,
    input  logic [ID_BITS-1:0]     i_next_slot,
    input  logic                   i_prefix,
    output logic [ID_BITS-1:0]     o_slot,
    output logic                   o_prefix,
    output logic                   o_first_below,
    output logic                   o_first_last,
    output logic [ID_BITS-1:0]     o_pick
);

    localparam logic [CNT_W-1:0] L_IDX  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] L_IDX1 = CNT_W'(IDX + 1);

    logic [ID_BITS-1:0] r_slot;
    logic               r_hit;
    logic               w_occ;
    logic               w_first;
    logic               w_kill;

    // The cell holds a live entry when its position is below the count.
    assign w_occ = L_IDX < i_count;

    // Hit chain: a cell is the first match when no cell below it matched.
    assign w_first       = r_hit & ~i_prefix;
    assign o_prefix      = i_prefix | r_hit;
    assign o_first_below = w_first & (L_IDX < i_cursor);
    assign o_first_last  = w_first & (L_IDX1 == i_cursor);

    // Entry at the iterator position, zero elsewhere, for the OR reduction.
    assign o_pick = (L_IDX == i_cursor) ? r_slot : '0;
    assign o_slot = r_slot;

    // Decide whether this cell takes its upper neighbor's entry.
    always_comb begin
        unique case (i_ctl.kill)
            idq_pkg::KILL_NONE:   w_kill = 1'b0;
            idq_pkg::KILL_ALL:    w_kill = 1'b1;
            idq_pkg::KILL_HIT:    w_kill = o_prefix;
            idq_pkg::KILL_CURSOR: w_kill = L_IDX1 >= i_cursor;
            default:              w_kill = 1'b0;
        endcase
    end

    // Entry storage: append writes the cell at the tail, removal shifts down.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load && (L_IDX == i_count)) begin
            r_slot <= i_value;
        end else if (i_ctl.shift && w_kill) begin
            r_slot <= i_next_slot;
        end
        if (i_ctl.cmp) begin
            r_hit <= w_occ && (r_slot == i_value);
        end
    end

endmodule

### rtl/id_queue_with_removal.sv
// Ordered id queue with removal by value and an iterator.
// A request is captured on acceptance, compared across the cell row in ST_CMP, and
// in ST_EXEC the row is updated and the result register loaded. No new request is
// accepted until the last one has finished ST_EXEC. The update cycle waits while an
// older result is stalled. Reset clears state, count, iterator, the returned flag and
// output valid; the entries themselves are not cleared. Uses idq_pkg, idq_cell.
module id_queue_with_removal #(
    parameter int DEPTH   = 64,
    parameter int ID_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_req_type,
    input  logic [15:0] i_item_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_ok,
    output logic [15:0] o_result_value,
    output logic        o_more_to_iterate,
    output logic        o_is_empty,
    output logic [6:0]  o_entry_count
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] L_DEPTH = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] L_ONE   = CNT_W'(1);

    idq_pkg::t_state    r_state, n_state;
    idq_pkg::t_req      r_req;
    logic [ID_BITS-1:0] r_value;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_cursor, n_cursor;
    logic               r_rv, n_rv;

    logic               r_out_valid;
    logic               r_ok, n_ok;
    logic [ID_BITS-1:0] r_res, n_res;
    logic               r_more;
    logic               r_empty;
    logic [CNT_W-1:0]   r_cnt;

    idq_pkg::t_cell_ctl w_ctl;
    logic               w_accept;
    logic               w_can_out;
    logic               w_fire;

    logic [ID_BITS-1:0] w_slot [DEPTH];
    logic [ID_BITS-1:0] w_pick [DEPTH];
    logic [DEPTH:0]     w_prefix;
    logic [DEPTH-1:0]   w_first_below;
    logic [DEPTH-1:0]   w_first_last;
    logic [ID_BITS-1:0] w_pick_or;
    logic               w_found;

    logic [ID_BITS+15:0] w_in_wide;
    logic [ID_BITS+15:0] w_res_wide;
    logic [CNT_W+6:0]    w_cnt_wide;

    // Handshake on both channels.
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = r_state != idq_pkg::ST_IDLE;
    assign w_can_out  = !r_out_valid || !i_out_stall;
    assign w_fire     = (r_state == idq_pkg::ST_EXEC) && w_can_out;

    // Input id trimmed or extended to the stored width.
    assign w_in_wide = {{ID_BITS{1'b0}}, i_item_value};

    // Row of cells, each handing its entry and hit prefix to its neighbor.
    assign w_prefix[0] = 1'b0;
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [ID_BITS-1:0] w_next;
        if (g == DEPTH - 1) begin : g_top
            assign w_next = w_slot[g];
        end else begin : g_mid
            assign w_next = w_slot[g+1];
        end
        idq_cell #(
            .IDX     (g),
            .CNT_W   (CNT_W),
            .ID_BITS (ID_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_value       (r_value),
            .i_count       (r_count),
            .i_cursor      (r_cursor),
            .i_next_slot   (w_next),
            .i_prefix      (w_prefix[g]),
            .o_slot        (w_slot[g]),
            .o_prefix      (w_prefix[g+1]),
            .o_first_below (w_first_below[g]),
            .o_first_last  (w_first_last[g]),
            .o_pick        (w_pick[g])
        );
    end

    assign w_found = w_prefix[DEPTH];

    // OR reduction of the entry at the iterator position.
    always_comb begin
        w_pick_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_pick_or = w_pick_or | w_pick[i];
        end
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= idq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state, cell controls and the outcome of the current request.
    always_comb begin
        n_state    = r_state;
        w_ctl      = '0;
        w_ctl.kill = idq_pkg::KILL_NONE;
        n_count    = r_count;
        n_cursor   = r_cursor;
        n_rv       = r_rv;
        n_ok       = 1'b0;
        n_res      = '0;

        unique case (r_state)
            idq_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = idq_pkg::ST_CMP;
                end
            end
            idq_pkg::ST_CMP: begin
                w_ctl.cmp = 1'b1;
                n_state   = idq_pkg::ST_EXEC;
            end
            idq_pkg::ST_EXEC: begin
                if (w_can_out) begin
                    n_state = idq_pkg::ST_IDLE;
                end
            end
            default: n_state = idq_pkg::ST_IDLE;
        endcase

        unique case (r_req)
            idq_pkg::REQ_ADD: begin
                if (r_count < L_DEPTH) begin
                    w_ctl.load = 1'b1;
                    n_count    = r_count + L_ONE;
                    n_ok       = 1'b1;
                end
            end
            idq_pkg::REQ_POLL: begin
                if (r_count != '0) begin
                    w_ctl.shift = 1'b1;
                    w_ctl.kill  = idq_pkg::KILL_ALL;
                    n_res       = w_slot[0];
                    n_count     = r_count - L_ONE;
                    n_ok        = 1'b1;
                    if (r_cursor != '0) begin
                        n_cursor = r_cursor - L_ONE;
                        if (r_cursor == L_ONE) begin
                            n_rv = 1'b0;
                        end
                    end
                end
            end
            idq_pkg::REQ_REMOVE: begin
                if (w_found) begin
                    w_ctl.shift = 1'b1;
                    w_ctl.kill  = idq_pkg::KILL_HIT;
                    n_count     = r_count - L_ONE;
                    n_ok        = 1'b1;
                    if (|w_first_below) begin
                        n_cursor = r_cursor - L_ONE;
                        if (|w_first_last) begin
                            n_rv = 1'b0;
                        end
                    end
                end
            end
            idq_pkg::REQ_CONTAINS: begin
                n_ok = w_found;
            end
            idq_pkg::REQ_REWIND: begin
                n_cursor = '0;
                n_rv     = 1'b0;
                n_ok     = 1'b1;
            end
            idq_pkg::REQ_NEXT: begin
                if (r_cursor < r_count) begin
                    n_res    = w_pick_or;
                    n_cursor = r_cursor + L_ONE;
                    n_rv     = 1'b1;
                    n_ok     = 1'b1;
                end
            end
            idq_pkg::REQ_REMOVE_CUR: begin
                if (r_rv && (r_cursor != '0)) begin
                    w_ctl.shift = 1'b1;
                    w_ctl.kill  = idq_pkg::KILL_CURSOR;
                    n_count     = r_count - L_ONE;
                    n_cursor    = r_cursor - L_ONE;
                    n_rv        = 1'b0;
                    n_ok        = 1'b1;
                end
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase

        // Updates only take effect in the cycle the result is registered.
        if (!w_fire) begin
            w_ctl.load  = 1'b0;
            w_ctl.shift = 1'b0;
        end
    end

    // Queue status registers and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cursor    <= '0;
            r_rv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_count  <= n_count;
                r_cursor <= n_cursor;
                r_rv     <= n_rv;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request capture and result payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req   <= idq_pkg::t_req'(i_req_type);
            r_value <= w_in_wide[ID_BITS-1:0];
        end
        if (w_fire) begin
            r_ok    <= n_ok;
            r_res   <= n_res;
            r_more  <= n_cursor < n_count;
            r_empty <= n_count == '0;
            r_cnt   <= n_count;
        end
    end

    // Output ports at their fixed widths.
    assign w_res_wide        = {16'b0, r_res};
    assign w_cnt_wide        = {7'b0, r_cnt};
    assign o_out_valid       = r_out_valid;
    assign o_ok              = r_ok;
    assign o_result_value    = w_res_wide[15:0];
    assign o_more_to_iterate = r_more;
    assign o_is_empty        = r_empty;
    assign o_entry_count     = w_cnt_wide[6:0];

`ifndef NO_ASSERTIONS
    // The iterator never runs past the last entry.
    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= r_count)
        else $error("iterator position beyond entry count");

    // The entry count never exceeds the row length.
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= L_DEPTH)
        else $error("entry count beyond depth");

    // A new result appears only right after the update cycle.
    a_result_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == idq_pkg::ST_EXEC))
        else $error("result register loaded outside the update cycle");

    // Status only changes when a result is loaded.
    a_status_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != idq_pkg::ST_EXEC) |=> $stable(r_count) && $stable(r_cursor))
        else $error("queue status changed outside the update cycle");
`endif

endmodule

### sim/id_queue_checker.sv
// Checker for the id queue: watches both channels, predicts each result and compares it.
// Depends on idq_pkg for the request codes; instantiated beside the block by the testbench.
module id_queue_checker #(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [2:0]  i_req_type,
    input  logic [15:0] i_item_value,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_ok,
    input  logic [15:0] i_result_value,
    input  logic        i_more_to_iterate,
    input  logic        i_is_empty,
    input  logic [6:0]  i_entry_count,
    output int          o_error_count,
    output int          o_pending_count,
    output int          o_checked_count,
    output int          o_full_reject_count
);

    // One predicted response transaction.
    typedef struct {
        logic        ok;
        logic [15:0] value;
        logic        more;
        logic        empty;
        logic [6:0]  count;
    } t_outcome;

    // Shadow copy of the queue contents and iterator.
    logic [15:0] id_slots [DEPTH];
    int          fill;
    int          cursor;
    bit          returned_live;
    t_outcome    outcome_q [$];

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        o_error_count++;
    endtask

    function automatic bit find_id(input logic [15:0] id, output int where);
        where = 0;
        for (int i = 0; i < fill; i++) begin
            if (id_slots[i] == id) begin
                where = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Close the gap left by an entry and keep the iterator on the same entry.
    task automatic drop_entry(input int idx);
        if (idx < fill) begin
            for (int i = idx; i + 1 < fill; i++) begin
                id_slots[i] = id_slots[i + 1];
            end
            fill--;
            if (idx < cursor) begin
                if (returned_live && idx + 1 == cursor) begin
                    returned_live = 1'b0;
                end
                cursor--;
            end
        end
    endtask

    // Applies one request to the shadow queue and works out its response.
    task automatic predict_request(input idq_pkg::t_req req, input logic [15:0] id,
                                   output t_outcome o);
        int          idx;
        logic [15:0] taken;
        bit          done;
        taken = '0;
        done  = 1'b0;
        case (req)
            idq_pkg::REQ_ADD: begin
                if (fill < DEPTH) begin
                    id_slots[fill] = id;
                    fill++;
                    done = 1'b1;
                end else begin
                    o_full_reject_count++;
                end
            end
            idq_pkg::REQ_POLL: begin
                if (fill > 0) begin
                    taken = id_slots[0];
                    drop_entry(0);
                    done = 1'b1;
                end
            end
            idq_pkg::REQ_REMOVE: begin
                if (find_id(id, idx)) begin
                    drop_entry(idx);
                    done = 1'b1;
                end
            end
            idq_pkg::REQ_CONTAINS: begin
                done = find_id(id, idx);
            end
            idq_pkg::REQ_REWIND: begin
                cursor        = 0;
                returned_live = 1'b0;
                done          = 1'b1;
            end
            idq_pkg::REQ_NEXT: begin
                if (cursor < fill) begin
                    taken         = id_slots[cursor];
                    cursor++;
                    returned_live = 1'b1;
                    done          = 1'b1;
                end
            end
            idq_pkg::REQ_REMOVE_CUR: begin
                if (returned_live && cursor > 0) begin
                    drop_entry(cursor - 1);
                    returned_live = 1'b0;
                    done          = 1'b1;
                end
            end
            default: begin
            end
        endcase
        o.ok    = done;
        o.value = done ? taken : 16'd0;
        o.more  = (cursor < fill);
        o.empty = (fill == 0);
        o.count = fill[6:0];
    endtask

    // Compare each response transaction, then predict for each request transaction.
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            fill                = 0;
            cursor              = 0;
            returned_live       = 1'b0;
            o_error_count       = 0;
            o_checked_count     = 0;
            o_full_reject_count = 0;
            outcome_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (outcome_q.size() == 0) begin
                    report_mismatch("response with no request outstanding");
                end else begin
                    want = outcome_q.pop_front();
                    o_checked_count++;
                    if (i_ok !== want.ok)
                        report_mismatch($sformatf("ok got %b want %b", i_ok, want.ok));
                    if (i_result_value !== want.value)
                        report_mismatch($sformatf("result_value got %h want %h",
                                                  i_result_value, want.value));
                    if (i_more_to_iterate !== want.more)
                        report_mismatch($sformatf("more_to_iterate got %b want %b",
                                                  i_more_to_iterate, want.more));
                    if (i_is_empty !== want.empty)
                        report_mismatch($sformatf("is_empty got %b want %b",
                                                  i_is_empty, want.empty));
                    if (i_entry_count !== want.count)
                        report_mismatch($sformatf("entry_count got %0d want %0d",
                                                  i_entry_count, want.count));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_request(idq_pkg::t_req'(i_req_type), i_item_value, want);
                outcome_q.push_back(want);
            end
        end
        o_pending_count = outcome_q.size();
    end

endmodule

### sim/id_queue_with_removal_tb.sv
// Testbench top for id_queue_with_removal: clock, reset, request stimulus and verdict.
// Depends on idq_pkg, the block itself and id_queue_checker, which checks all responses.
module id_queue_with_removal_tb;

    localparam int RANDOM_ITEMS = 500;
    localparam int QUIET_LIMIT  = 2000;

    typedef enum {MODE_FILL, MODE_DRAIN, MODE_WALK, MODE_MIXED} t_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_req_type;
    logic [15:0] i_item_value;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_ok;
    logic [15:0] o_result_value;
    logic        o_more_to_iterate;
    logic        o_is_empty;
    logic [6:0]  o_entry_count;

    int          error_count;
    int          pending_count;
    int          checked_count;
    int          full_reject_count;
    int          quiet_cycles = 0;
    int          items_sent = 0;
    bit          idling_on = 1'b1;
    logic [15:0] id_pool [8];

    always #5 i_clk = ~i_clk;

    id_queue_with_removal dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_req_type        (i_req_type),
        .i_item_value      (i_item_value),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_ok              (o_ok),
        .o_result_value    (o_result_value),
        .o_more_to_iterate (o_more_to_iterate),
        .o_is_empty        (o_is_empty),
        .o_entry_count     (o_entry_count)
    );

    id_queue_checker checker_inst (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .i_in_stall          (o_in_stall),
        .i_req_type          (i_req_type),
        .i_item_value        (i_item_value),
        .i_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .i_ok                (o_ok),
        .i_result_value      (o_result_value),
        .i_more_to_iterate   (o_more_to_iterate),
        .i_is_empty          (o_is_empty),
        .i_entry_count       (o_entry_count),
        .o_error_count       (error_count),
        .o_pending_count     (pending_count),
        .o_checked_count     (checked_count),
        .o_full_reject_count (full_reject_count)
    );

    // Random back-pressure on the response side.
    always @(negedge i_clk) begin
        i_out_stall <= idling_on && ($urandom_range(99) < 15);
    end

    // Ends the run if no transaction moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Offers one request transaction, with an occasional gap first, and waits for acceptance.
    task automatic send_req(input idq_pkg::t_req req, input logic [15:0] id);
        @(negedge i_clk);
        while (idling_on && $urandom_range(99) < 15) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_item_value <= id;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    function automatic idq_pkg::t_req any_req();
        return idq_pkg::t_req'($urandom_range(6));
    endfunction

    // Request mix for each kind of random segment.
    function automatic idq_pkg::t_req pick_req(input t_mode m);
        int roll;
        roll = $urandom_range(99);
        case (m)
            MODE_FILL:  return (roll < 90) ? idq_pkg::REQ_ADD : any_req();
            MODE_DRAIN: begin
                if (roll < 40) return idq_pkg::REQ_POLL;
                if (roll < 70) return idq_pkg::REQ_REMOVE;
                if (roll < 80) return idq_pkg::REQ_CONTAINS;
                return any_req();
            end
            MODE_WALK: begin
                if (roll < 40) return idq_pkg::REQ_NEXT;
                if (roll < 60) return idq_pkg::REQ_REMOVE_CUR;
                if (roll < 70) return idq_pkg::REQ_REWIND;
                if (roll < 85) return idq_pkg::REQ_ADD;
                return idq_pkg::REQ_REMOVE;
            end
            default:    return any_req();
        endcase
    endfunction

    // Mostly ids from a small pool so that searches and removals hit.
    function automatic logic [15:0] pick_id();
        if ($urandom_range(99) < 75) return id_pool[$urandom_range(7)];
        return 16'($urandom_range(65535));
    endfunction

    initial begin
        t_mode m;
        int    seg_len;
        int    random_sent;
        bit    first_seg;

        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_req_type   = idq_pkg::REQ_ADD;
        i_item_value = '0;
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        for (int i = 2; i < 8; i++) begin
            id_pool[i] = 16'($urandom_range(65535));
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty-queue corners, extremes, iterator and removal cases.
        send_req(idq_pkg::REQ_REWIND, 16'h0000);
        send_req(idq_pkg::REQ_POLL, 16'h0000);
        send_req(idq_pkg::REQ_NEXT, 16'h0000);
        send_req(idq_pkg::REQ_REMOVE_CUR, 16'h0000);
        send_req(idq_pkg::REQ_REMOVE, 16'h1234);
        send_req(idq_pkg::REQ_CONTAINS, 16'h0000);
        send_req(idq_pkg::REQ_ADD, 16'h0000);
        send_req(idq_pkg::REQ_ADD, 16'hFFFF);
        send_req(idq_pkg::REQ_ADD, 16'h5A5A);
        send_req(idq_pkg::REQ_ADD, 16'hA5A5);
        send_req(idq_pkg::REQ_CONTAINS, 16'hFFFF);
        send_req(idq_pkg::REQ_NEXT, 16'h0000);
        send_req(idq_pkg::REQ_NEXT, 16'h0000);
        // Take out the entry just returned, then try again with nothing returned.
        send_req(idq_pkg::REQ_REMOVE_CUR, 16'h0000);
        send_req(idq_pkg::REQ_REMOVE_CUR, 16'h0000);
        // Removal ahead of the cursor pulls the cursor back.
        send_req(idq_pkg::REQ_REMOVE, 16'h0000);
        send_req(idq_pkg::REQ_NEXT, 16'h0000);
        send_req(idq_pkg::REQ_NEXT, 16'h0000);
        send_req(idq_pkg::REQ_NEXT, 16'h0000);
        // An append with the iterator at the end becomes its next entry.
        send_req(idq_pkg::REQ_ADD, 16'h1111);
        send_req(idq_pkg::REQ_NEXT, 16'h0000);
        send_req(idq_pkg::REQ_POLL, 16'h0000);
        send_req(idq_pkg::REQ_POLL, 16'h0000);
        send_req(idq_pkg::REQ_POLL, 16'h0000);
        send_req(idq_pkg::REQ_POLL, 16'h0000);

        // Random part in segments; the first one fills the queue past full.
        random_sent = 0;
        first_seg   = 1'b1;
        while (random_sent < RANDOM_ITEMS) begin
            m         = first_seg ? MODE_FILL : t_mode'($urandom_range(3));
            seg_len   = first_seg ? 80 : $urandom_range(20, 60);
            first_seg = 1'b0;
            for (int k = 0; k < seg_len && random_sent < RANDOM_ITEMS; k++) begin
                // A long stretch in the middle runs with no request gaps and no response back-pressure.
                idling_on = !(random_sent >= 250 && random_sent < 340);
                send_req(pick_req(m), pick_id());
                random_sent++;
            end
        end
        idling_on = 1'b1;
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // Drain the outstanding responses before the verdict.
        do @(negedge i_clk); while (pending_count != 0);
        repeat (8) @(negedge i_clk);

        $display("Sent %0d requests of all seven kinds and checked %0d responses.",
                 items_sent, checked_count);
        $display("Adds refused on a full queue: %0d.", full_reject_count);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
